// ----- rtl/core/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master core
// Field widths, action/kind/status codes and the beat structures that pass
// between the top level and the bit-level controller.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // field widths
    localparam int ACT_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int PHASE_W     = 2;
    localparam int BIT_W       = 3;
    // wide enough to hold any buffer depth in range
    localparam int DEPTH_CMP_W = 9;

    localparam int BUFFER_DEPTH_DEF = 64;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START = 2'd2;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_PROBE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REGWR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAWWR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    // completion status
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_START_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NACK       = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_READ  = 2'd3;

    // address byte masks and shift MSB
    localparam logic [BYTE_W-1:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [BYTE_W-1:0] ADDR_RD_BIT  = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_MSB     = 8'h80;

    // one input beat
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              sda_in;
        logic [BYTE_W-1:0] device_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [IDX_W-1:0]  buf_index;
        logic [BYTE_W-1:0] buf_byte;
        logic [LEN_W-1:0]  length;
        logic [KIND_W-1:0] kind;
    } i2cm_item_t;

    // one result beat
    typedef struct packed {
        logic                scl_level;
        logic                sda_release;
        logic                busy_res;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic                read_valid;
        logic [IDX_W-1:0]    read_index;
        logic [BYTE_W-1:0]   read_data;
    } i2cm_result_t;

endpackage

// ----- rtl/core/i2cm_ram.sv -----
// ----------------------------------------------------------------------------
// i2cm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/i2cm_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2cm_ctrl: I2C bit-level sequencer
// Holds the transaction state and the line levels, advances them by one beat
// per step and produces that beat's result. Owns the write buffer RAM.
// ----------------------------------------------------------------------------
module i2cm_ctrl #(
    parameter int BUFFER_DEPTH = i2cm_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  i2cm_pkg::i2cm_item_t   item,
    output i2cm_pkg::i2cm_result_t result
);
    import i2cm_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [DEPTH_CMP_W-1:0] DEPTH_CMP = DEPTH_CMP_W'(BUFFER_DEPTH);
    localparam logic [LEN_W-1:0]       DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

    // sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [ST_W-1:0] ST_START      = 4'd1;
    localparam logic [ST_W-1:0] ST_ADDR_W     = 4'd2;
    localparam logic [ST_W-1:0] ST_ACK1       = 4'd3;
    localparam logic [ST_W-1:0] ST_REG        = 4'd4;
    localparam logic [ST_W-1:0] ST_ACK_REG    = 4'd5;
    localparam logic [ST_W-1:0] ST_DATA       = 4'd6;
    localparam logic [ST_W-1:0] ST_ACK_DATA   = 4'd7;
    localparam logic [ST_W-1:0] ST_STOP_MID   = 4'd8;
    localparam logic [ST_W-1:0] ST_RSTART     = 4'd9;
    localparam logic [ST_W-1:0] ST_ADDR_R     = 4'd10;
    localparam logic [ST_W-1:0] ST_ACK_R      = 4'd11;
    localparam logic [ST_W-1:0] ST_RECV       = 4'd12;
    localparam logic [ST_W-1:0] ST_MACK       = 4'd13;
    localparam logic [ST_W-1:0] ST_STOP_FINAL = 4'd14;
    localparam logic [ST_W-1:0] ST_STOP_FAIL  = 4'd15;

    logic [ST_W-1:0]    st_reg, st_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [LEN_W-1:0]   byte_reg, byte_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BYTE_W-1:0]  dev_reg, dev_next;
    logic [BYTE_W-1:0]  rega_reg, rega_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               pend_reg, pend_next;

    logic [BYTE_W-1:0]   shift_cur;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                go;
    logic [ST_W-1:0]     go_st;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic                seg_end;
    logic                nack;
    logic                drop;
    logic                fail;
    logic                wr_en;
    logic                rd_en;
    logic                idx_ok;
    logic                len_small;
    logic [LEN_W:0]      mack_cnt;
    logic [AW+IDX_W-1:0] waddr_wide;
    logic [AW+LEN_W-1:0] raddr_wide;

    // buffer index and length range checks
    assign idx_ok     = {{(DEPTH_CMP_W-IDX_W){1'b0}}, item.buf_index} < DEPTH_CMP;
    assign len_small  = {{(DEPTH_CMP_W-LEN_W){1'b0}}, item.length} < DEPTH_CMP;
    assign mack_cnt   = {1'b0, byte_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign waddr_wide = {{AW{1'b0}}, item.buf_index};
    assign raddr_wide = {{AW{1'b0}}, byte_next};

    // a buffer byte fetched on entry is taken from the RAM while pending
    assign shift_cur = pend_reg ? ram_rdata : shift_reg;

    // next state and beat result
    always_comb
    begin
        st_next    = st_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_cur;
        dev_next   = dev_reg;
        rega_next  = rega_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        pend_next  = 1'b0;
        go         = 1'b0;
        go_st      = ST_IDLE;
        fin        = 1'b0;
        fin_status = STAT_OK;
        seg_end    = 1'b0;
        nack       = 1'b0;
        drop       = 1'b0;
        fail       = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        result             = '0;
        result.scl_level   = scl_reg;
        result.sda_release = sda_reg;

        case (item.action)
            ACT_LOAD:
            begin
                wr_en = idx_ok;
            end
            ACT_START:
            begin
                if (st_reg == ST_IDLE)
                begin
                    dev_next  = item.device_addr;
                    rega_next = item.reg_addr;
                    kind_next = item.kind;
                    len_next  = len_small ? item.length : DEPTH_LEN;
                    byte_next = '0;
                    if (item.kind == KIND_READ && item.length == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = STAT_ZERO_READ;
                    end
                    else
                    begin
                        go    = 1'b1;
                        go_st = ST_START;
                    end
                end
            end
            ACT_TICK:
            begin
                if (st_reg != ST_IDLE)
                begin
                    // line changes due before this delay
                    case (st_reg)
                        ST_START, ST_RSTART:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                scl_next = 1'b1;
                                sda_next = 1'b1;
                                fail     = (st_reg == ST_START) && !item.sda_in;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                sda_next = 1'b0;
                                fail     = (st_reg == ST_START) && item.sda_in;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                                seg_end  = 1'b1;
                            end
                            phase_next = phase_reg + 2'd1;
                        end
                        ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                scl_next   = 1'b0;
                                phase_next = 2'd1;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                sda_next   = (shift_cur & BYTE_MSB) != '0;
                                shift_next = {shift_cur[BYTE_W-2:0], 1'b0};
                                phase_next = 2'd2;
                            end
                            else
                            begin
                                scl_next   = 1'b1;
                                phase_next = 2'd0;
                                if (bit_reg == 3'd7)
                                begin
                                    drop    = 1'b1;
                                    seg_end = 1'b1;
                                end
                                else
                                begin
                                    bit_next = bit_reg + 3'd1;
                                end
                            end
                        end
                        ST_ACK1, ST_ACK_REG, ST_ACK_DATA, ST_ACK_R:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                scl_next = 1'b0;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                sda_next = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b1;
                                nack     = item.sda_in;
                                drop     = item.sda_in;
                                seg_end  = 1'b1;
                            end
                            phase_next = phase_reg + 2'd1;
                        end
                        ST_RECV:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                if (bit_reg == '0)
                                begin
                                    sda_next = 1'b1;
                                end
                                scl_next   = 1'b0;
                                phase_next = 2'd1;
                            end
                            else
                            begin
                                scl_next   = 1'b1;
                                shift_next = {shift_cur[BYTE_W-2:0], item.sda_in};
                                phase_next = 2'd0;
                                if (bit_reg == 3'd7)
                                begin
                                    drop              = 1'b1;
                                    seg_end           = 1'b1;
                                    result.read_valid = 1'b1;
                                    result.read_index = byte_reg[IDX_W-1:0];
                                    result.read_data  = shift_next;
                                end
                                else
                                begin
                                    bit_next = bit_reg + 3'd1;
                                end
                            end
                        end
                        ST_MACK:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                scl_next = 1'b0;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                // NACK on the last byte
                                sda_next = mack_cnt >= {1'b0, len_reg};
                            end
                            else if (phase_reg == 2'd2)
                            begin
                                scl_next = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                                seg_end  = 1'b1;
                            end
                            phase_next = phase_reg + 2'd1;
                        end
                        default:
                        begin
                            // stop segments
                            if (phase_reg == 2'd0)
                            begin
                                scl_next = 1'b0;
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                sda_next = 1'b0;
                            end
                            else if (phase_reg == 2'd2)
                            begin
                                scl_next = 1'b1;
                            end
                            else
                            begin
                                sda_next = 1'b1;
                                seg_end  = 1'b1;
                            end
                            phase_next = phase_reg + 2'd1;
                        end
                    endcase

                    // levels held during the delay
                    result.scl_level   = scl_next;
                    result.sda_release = sda_next;
                    if (drop)
                    begin
                        scl_next = 1'b0;
                    end

                    // segment sequencing
                    if (fail)
                    begin
                        fin        = 1'b1;
                        fin_status = STAT_START_FAIL;
                    end
                    else if (seg_end)
                    begin
                        go = 1'b1;
                        case (st_reg)
                            ST_START:
                                go_st = (kind_reg == KIND_RAWWR) ? ST_REG : ST_ADDR_W;
                            ST_ADDR_W:
                                go_st = ST_ACK1;
                            ST_REG:
                                go_st = (kind_reg == KIND_RAWWR) ? ST_ACK1 : ST_ACK_REG;
                            ST_ACK1:
                            begin
                                if (nack)
                                    go_st = ST_STOP_FAIL;
                                else if (kind_reg == KIND_PROBE)
                                    go_st = ST_STOP_FINAL;
                                else if (kind_reg == KIND_RAWWR)
                                    go_st = (byte_reg < len_reg) ? ST_DATA : ST_STOP_FINAL;
                                else
                                    go_st = ST_REG;
                            end
                            ST_ACK_REG:
                            begin
                                if (kind_reg == KIND_READ)
                                    go_st = ST_STOP_MID;
                                else
                                    go_st = (byte_reg < len_reg) ? ST_DATA : ST_STOP_FINAL;
                            end
                            ST_DATA:
                                go_st = ST_ACK_DATA;
                            ST_ACK_DATA:
                            begin
                                byte_next = byte_reg + 7'd1;
                                go_st = (byte_next < len_reg) ? ST_DATA : ST_STOP_FINAL;
                            end
                            ST_STOP_MID:
                                go_st = ST_RSTART;
                            ST_RSTART:
                                go_st = ST_ADDR_R;
                            ST_ADDR_R:
                                go_st = ST_ACK_R;
                            ST_ACK_R:
                                go_st = ST_RECV;
                            ST_RECV:
                                go_st = ST_MACK;
                            ST_MACK:
                            begin
                                byte_next = byte_reg + 7'd1;
                                go_st = (byte_next < len_reg) ? ST_RECV : ST_STOP_FINAL;
                            end
                            ST_STOP_FAIL:
                            begin
                                go         = 1'b0;
                                fin        = 1'b1;
                                fin_status = STAT_NACK;
                            end
                            default:
                            begin
                                go  = 1'b0;
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase

        // finish the transaction
        if (fin)
        begin
            st_next    = ST_IDLE;
            phase_next = '0;
            bit_next   = '0;
        end

        // enter a new segment; preload its shift byte or fetch it from the buffer
        if (go)
        begin
            st_next    = go_st;
            phase_next = '0;
            bit_next   = '0;
            case (go_st)
                ST_ADDR_W: shift_next = dev_next & ADDR_WR_MASK;
                ST_REG:    shift_next = rega_next;
                ST_ADDR_R: shift_next = dev_next | ADDR_RD_BIT;
                ST_RECV:   shift_next = '0;
                ST_DATA:
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        result.busy_res = st_next != ST_IDLE;
        result.done_res = fin;
        result.status   = fin ? fin_status : STAT_OK;
    end

    // state registers, updated once per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            phase_reg <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            dev_reg   <= '0;
            rega_reg  <= '0;
            len_reg   <= '0;
            kind_reg  <= KIND_PROBE;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            pend_reg  <= 1'b0;
        end
        else if (step)
        begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            dev_reg   <= dev_next;
            rega_reg  <= rega_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            pend_reg  <= pend_next;
        end
    end

    // write buffer
    i2cm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_wbuf (
        .clk   (clk),
        .we    (step && wr_en),
        .waddr (waddr_wide[AW-1:0]),
        .wdata (item.buf_byte),
        .re    (step && rd_en),
        .raddr (raddr_wide[AW-1:0]),
        .rdata (ram_rdata)
    );

    // checks
    a_pend_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (st_reg == ST_DATA && phase_reg == 2'd0))
        else $error("buffer fetch pending outside the first data phase");

    a_rvalid_recv: assert property (@(posedge clk) disable iff (!rst_n)
        result.read_valid |-> (st_reg == ST_RECV && bit_reg == 3'd7))
        else $error("received byte shown outside the last receive bit");

    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_START || st_reg == ST_RSTART) |-> (phase_reg != 2'd3))
        else $error("start segment ran past its third phase");

    a_busy_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.busy_res) |=> (st_reg != ST_IDLE))
        else $error("busy reported but sequencer went idle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.done_res) |=> (st_reg == ST_IDLE && phase_reg == '0))
        else $error("finished transaction left sequencer active");

endmodule

// ----- rtl/core/i2c_master_transaction_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transaction_core: bit-level I2C master
// Channel  Dir  Beat contents
// s_axis   in   tuser: action; tdata: sda_in, device_addr, reg_addr,
//               buf_index, buf_byte, length, kind
// m_axis   out  tdata: scl_level, sda_release, busy_res, done_res, status,
//               read_valid, read_index, read_data
//
// One beat per clock while m_axis does not stall; each input beat gives
// exactly one result beat, via the input register, then the result register.
// The sequencer state and the write buffer RAM advance only when the input
// register holds a beat and the result register can take its result.
// A stall on m_axis fills the result register and then the input register;
// s_axis_tready drops only when both are full.
// Reset clears the sequencer to idle with both lines released; the write
// buffer is not cleared.
// ----------------------------------------------------------------------------
module i2c_master_transaction_core #(
    parameter int BUFFER_DEPTH = i2cm_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sda_in, device_addr, reg_addr, buf_index, buf_byte, length, kind
    input  logic [39:0] s_axis_tdata,
    // action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_level, sda_release, busy_res, done_res, status, read_valid,
    // read_index, read_data, zero pad
    output logic [23:0] m_axis_tdata
);
    import i2cm_pkg::*;

    logic         in_valid_reg;
    i2cm_item_t   in_item_reg;
    logic         out_valid_reg;
    i2cm_result_t out_data_reg;
    i2cm_result_t step_result;
    i2cm_item_t   beat_item;
    logic         step;

    // unpack the input beat
    always_comb
    begin
        beat_item.action      = s_axis_tuser;
        beat_item.sda_in      = s_axis_tdata[0];
        beat_item.device_addr = s_axis_tdata[8:1];
        beat_item.reg_addr    = s_axis_tdata[16:9];
        beat_item.buf_index   = s_axis_tdata[22:17];
        beat_item.buf_byte    = s_axis_tdata[30:23];
        beat_item.length      = s_axis_tdata[37:31];
        beat_item.kind        = s_axis_tdata[39:38];
    end

    // advance when a beat waits and the result slot is free or draining
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= beat_item;
        end
    end

    // sequencer
    i2cm_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= step_result;
        end
    end

    // pack the result beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_data_reg.read_data,
                            out_data_reg.read_index,
                            out_data_reg.read_valid,
                            out_data_reg.status,
                            out_data_reg.done_res,
                            out_data_reg.busy_res,
                            out_data_reg.sda_release,
                            out_data_reg.scl_level};

endmodule
